// File: rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the I2C master bit engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_WACK  = 3'd4,
        CMD_READ  = 3'd5
    } cmd_t;

    // one tick as it travels through the queue
    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] data_byte;
        logic       send_ack;
        logic       sda_in;
    } item_t;

    // queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    localparam logic [7:0] TIMEOUT_RESET = 8'd250;
    localparam logic [7:0] MSB_MASK      = 8'h80;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;
    localparam logic [3:0] ACK_BIT_DONE  = 4'd9;

    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 16;

endpackage

// File: rtl/i2c_master_bit_engine_top.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_top
// A tick beat is written into the queue, then its result is captured in the
// result register and held there until it is taken.
// Throughput: one tick beat per cycle while the queue is not full.
// The queue (FIFO_DEPTH beats) absorbs output stalls before s_tready drops.
// Reset (aresetn low, synchronous): idle, SCL/SDA released, timeout 250.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_top #(
    parameter int FIFO_DEPTH = 2    // tick beats buffered front to back, 2 or more
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config write channel: ack_timeout
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    // tick beats in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [7:0] data_byte, [8] send_ack, [9] sda_in, rest zero
    input  logic [2:0]  s_tuser,    // [2:0] op
    // result beats out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata     // [0] scl_level, [1] sda_level, [2] busy_res,
                                    // [3] done_res, [11:4] rx_byte, [12] ack_missing
);

    logic [7:0]        ack_timeout_reg;
    logic              push;
    logic              pop;
    i2cm_pkg::item_t   push_item;
    i2cm_pkg::item_t   pop_item;
    i2cm_pkg::q_stat_t q_stat;

    // config is to be written by the user only while the engine is idle (not enforced here); always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ack_timeout_reg <= i2cm_pkg::TIMEOUT_RESET;
        end else if (cfg_valid) begin
            ack_timeout_reg <= cfg_data;
        end
    end

    // front: unpack and classify each tick beat
    i2cm_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_stat    (q_stat),
        .push      (push),
        .push_item (push_item)
    );

    // queue lets front and back stall independently
    i2cm_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .q_stat    (q_stat)
    );

    // back: one sequencer step per popped tick, registered result
    i2cm_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ack_timeout (ack_timeout_reg),
        .q_stat      (q_stat),
        .pop_item    (pop_item),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

// File: rtl/i2cm_front.sv
// ----------------------------------------------------------------------------
// i2cm_front
// Input side: unpacks a beat, maps unused op codes to none, pushes the queue.
// ----------------------------------------------------------------------------
module i2cm_front (
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [i2cm_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic [i2cm_pkg::S_TUSER_W-1:0]     s_tuser,
    input  i2cm_pkg::q_stat_t                  q_stat,
    output logic                               push,
    output i2cm_pkg::item_t                    push_item
);

    i2cm_pkg::cmd_t cmd;

    always_comb begin
        unique case (s_tuser)
            i2cm_pkg::CMD_START: cmd = i2cm_pkg::CMD_START;
            i2cm_pkg::CMD_STOP:  cmd = i2cm_pkg::CMD_STOP;
            i2cm_pkg::CMD_WRITE: cmd = i2cm_pkg::CMD_WRITE;
            i2cm_pkg::CMD_WACK:  cmd = i2cm_pkg::CMD_WACK;
            i2cm_pkg::CMD_READ:  cmd = i2cm_pkg::CMD_READ;
            default:             cmd = i2cm_pkg::CMD_NONE;
        endcase
    end

    assign s_tready            = !q_stat.full;
    assign push                = s_tvalid && !q_stat.full;
    assign push_item.cmd       = cmd;
    assign push_item.data_byte = s_tdata[7:0];
    assign push_item.send_ack  = s_tdata[8];
    assign push_item.sda_in    = s_tdata[9];

endmodule

// File: rtl/i2cm_fifo.sv
// ----------------------------------------------------------------------------
// i2cm_fifo
// Short register queue between front and back (DEPTH 2 or more).
// ----------------------------------------------------------------------------
module i2cm_fifo #(
    parameter int DEPTH = 2
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  i2cm_pkg::item_t    push_item,
    input  logic               pop,
    output i2cm_pkg::item_t    pop_item,
    output i2cm_pkg::q_stat_t  q_stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    i2cm_pkg::item_t    mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign pop_item     = mem_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);

endmodule

// File: rtl/i2cm_back.sv
// ----------------------------------------------------------------------------
// i2cm_back
// Line sequencer: one step per queued tick, result held in an output register.
// ----------------------------------------------------------------------------
module i2cm_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [7:0]                         ack_timeout,
    input  i2cm_pkg::q_stat_t                  q_stat,
    input  i2cm_pkg::item_t                    pop_item,
    output logic                               pop,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [i2cm_pkg::M_TDATA_W-1:0]     m_tdata
);

    // sequencer state
    i2cm_pkg::cmd_t cmd_reg, cmd_next;
    logic [1:0]     phase_reg, phase_next;
    logic [3:0]     bit_cnt_reg, bit_cnt_next;
    logic [7:0]     shift_reg, shift_next;
    logic [7:0]     wait_cnt_reg, wait_cnt_next;
    logic           scl_reg, scl_next;
    logic           sda_reg, sda_next;
    logic           ack_choice_reg, ack_choice_next;
    logic [7:0]     rx_reg, rx_next;

    // result register
    logic                           out_valid_reg, out_valid_next;
    logic [i2cm_pkg::M_TDATA_W-1:0] out_data_reg;

    // values after a possible command load
    i2cm_pkg::cmd_t eff_cmd;
    logic           load;
    logic [1:0]     ph;
    logic [3:0]     bc;
    logic [7:0]     wc;
    logic [7:0]     sh;
    logic           ack_c;
    logic [3:0]     bc_inc;
    logic [8:0]     wc_inc;
    logic           wc_over;
    logic           done;
    logic           missing;
    logic [7:0]     rd_shift;

    assign pop = !q_stat.empty && (!out_valid_reg || m_tready);

    always_comb begin
        load    = (cmd_reg == i2cm_pkg::CMD_NONE) && (pop_item.cmd != i2cm_pkg::CMD_NONE);
        eff_cmd = load ? pop_item.cmd : cmd_reg;
        ph      = load ? 2'd0 : phase_reg;
        bc      = load ? 4'd0 : bit_cnt_reg;
        wc      = load ? 8'd0 : wait_cnt_reg;
        ack_c   = (load && pop_item.cmd == i2cm_pkg::CMD_READ) ? pop_item.send_ack
                                                               : ack_choice_reg;
        if (load && pop_item.cmd == i2cm_pkg::CMD_WRITE) begin
            sh = pop_item.data_byte;
        end else if (load && pop_item.cmd == i2cm_pkg::CMD_READ) begin
            sh = 8'd0;
        end else begin
            sh = shift_reg;
        end
        bc_inc   = bc + 4'd1;
        wc_inc   = {1'b0, wc} + 9'd1;
        wc_over  = wc_inc > {1'b0, ack_timeout};
        rd_shift = {sh[6:0], pop_item.sda_in};
    end

    // line levels, data path and done flags
    always_comb begin
        scl_next      = scl_reg;
        sda_next      = sda_reg;
        shift_next    = sh;
        bit_cnt_next  = bc;
        wait_cnt_next = wc;
        rx_next       = rx_reg;
        done          = 1'b0;
        missing       = 1'b0;
        unique case (eff_cmd)
            i2cm_pkg::CMD_START: begin
                if (ph == 2'd0) begin
                    sda_next = 1'b1;
                    scl_next = 1'b1;
                end else if (ph == 2'd1) begin
                    sda_next = 1'b0;
                end else begin
                    scl_next = 1'b0;
                    done     = 1'b1;
                end
            end
            i2cm_pkg::CMD_STOP: begin
                if (ph == 2'd0) begin
                    sda_next = 1'b0;
                    scl_next = 1'b0;
                end else begin
                    scl_next = 1'b1;
                    sda_next = 1'b1;
                    done     = 1'b1;
                end
            end
            i2cm_pkg::CMD_WRITE: begin
                if (ph == 2'd0) begin
                    scl_next   = 1'b0;
                    sda_next   = |(sh & i2cm_pkg::MSB_MASK);
                    shift_next = {sh[6:0], 1'b0};
                end else if (ph == 2'd1) begin
                    scl_next     = 1'b1;
                    bit_cnt_next = bc_inc;
                end else begin
                    scl_next = 1'b0;
                    done     = 1'b1;
                end
            end
            i2cm_pkg::CMD_WACK: begin
                if (ph <= 2'd1) begin
                    if (ph == 2'd0) begin
                        sda_next = 1'b1;
                        scl_next = 1'b1;
                    end
                    if (!pop_item.sda_in) begin
                        scl_next = 1'b0;
                        done     = 1'b1;
                    end else if (!wc_over) begin
                        wait_cnt_next = wc_inc[7:0];
                    end
                end else if (ph == 2'd2) begin
                    sda_next = 1'b0;
                    scl_next = 1'b0;
                end else begin
                    scl_next = 1'b1;
                    sda_next = 1'b1;
                    done     = 1'b1;
                    missing  = 1'b1;
                end
            end
            i2cm_pkg::CMD_READ: begin
                if (ph == 2'd0) begin
                    sda_next = 1'b1;
                    scl_next = 1'b0;
                end else if (ph == 2'd1) begin
                    scl_next     = 1'b1;
                    shift_next   = rd_shift;
                    bit_cnt_next = bc_inc;
                    if (bc_inc >= i2cm_pkg::BITS_PER_BYTE) begin
                        rx_next = rd_shift;
                    end
                end else if (ph == 2'd2) begin
                    scl_next = 1'b0;
                    if (bc >= i2cm_pkg::ACK_BIT_DONE) begin
                        done = 1'b1;
                    end else begin
                        sda_next = !ack_c;
                    end
                end else begin
                    scl_next     = 1'b1;
                    bit_cnt_next = i2cm_pkg::ACK_BIT_DONE;
                end
            end
            default: begin
            end
        endcase
        if (done) begin
            bit_cnt_next  = 4'd0;
            wait_cnt_next = 8'd0;
        end
        ack_choice_next = ack_c;
    end

    // command and phase
    always_comb begin
        cmd_next   = eff_cmd;
        phase_next = ph;
        unique case (eff_cmd)
            i2cm_pkg::CMD_START: begin
                if (ph == 2'd0) begin
                    phase_next = 2'd1;
                end else if (ph == 2'd1) begin
                    phase_next = 2'd2;
                end
            end
            i2cm_pkg::CMD_STOP: begin
                if (ph == 2'd0) begin
                    phase_next = 2'd1;
                end
            end
            i2cm_pkg::CMD_WRITE: begin
                if (ph == 2'd0) begin
                    phase_next = 2'd1;
                end else if (ph == 2'd1) begin
                    phase_next = (bc_inc >= i2cm_pkg::BITS_PER_BYTE) ? 2'd2 : 2'd0;
                end
            end
            i2cm_pkg::CMD_WACK: begin
                if (ph <= 2'd1) begin
                    phase_next = (pop_item.sda_in && wc_over) ? 2'd2 : 2'd1;
                end else if (ph == 2'd2) begin
                    phase_next = 2'd3;
                end
            end
            i2cm_pkg::CMD_READ: begin
                if (ph == 2'd0) begin
                    phase_next = 2'd1;
                end else if (ph == 2'd1) begin
                    phase_next = (bc_inc >= i2cm_pkg::BITS_PER_BYTE) ? 2'd2 : 2'd0;
                end else if (ph == 2'd2) begin
                    phase_next = 2'd3;
                end else begin
                    phase_next = 2'd2;
                end
            end
            default: begin
                cmd_next = i2cm_pkg::CMD_NONE;
            end
        endcase
        if (done) begin
            cmd_next   = i2cm_pkg::CMD_NONE;
            phase_next = 2'd0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (pop) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg        <= i2cm_pkg::CMD_NONE;
            phase_reg      <= 2'd0;
            bit_cnt_reg    <= 4'd0;
            shift_reg      <= 8'd0;
            wait_cnt_reg   <= 8'd0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            ack_choice_reg <= 1'b0;
            rx_reg         <= 8'd0;
            out_valid_reg  <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (pop) begin
                cmd_reg        <= cmd_next;
                phase_reg      <= phase_next;
                bit_cnt_reg    <= bit_cnt_next;
                shift_reg      <= shift_next;
                wait_cnt_reg   <= wait_cnt_next;
                scl_reg        <= scl_next;
                sda_reg        <= sda_next;
                ack_choice_reg <= ack_choice_next;
                rx_reg         <= rx_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_data_reg <= {3'd0, missing, rx_next, done,
                             (cmd_next != i2cm_pkg::CMD_NONE), sda_next, scl_next};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: rtl/i2cm_chk.sv
// ----------------------------------------------------------------------------
// i2cm_chk
// Port-level checks of the I2C master bit engine, bound to the top level.
// ----------------------------------------------------------------------------
module i2cm_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // stalled result beat stays
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat dropped or changed while stalled");

    // a finishing tick leaves the engine idle
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> !m_tdata[2])
        else $error("done with busy still set");

    // timeout only on the done tick of the forced stop, lines released
    a_missing_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[12] |-> m_tdata[3] && m_tdata[0] && m_tdata[1])
        else $error("ack_missing outside the stop done tick");

    // spare bits stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:13] == 3'd0)
        else $error("nonzero pad bits in result beat");

endmodule

bind i2c_master_bit_engine_top i2cm_chk u_chk (.*);
